// ----- sv/b64_pkg.sv -----
package b64_pkg;

    // ascii code of the pad character
    localparam logic [6:0] PAD_CODE = 7'd61;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // leftover bit counts held by the front
    localparam logic [2:0] CNT_ZERO = 3'd0;
    localparam logic [2:0] CNT_TWO  = 3'd2;
    localparam logic [2:0] CNT_FOUR = 3'd4;

    // one queued request: up to four characters for one input byte
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } entry_t;

    // map a sextet onto the standard alphabet
    function automatic logic [6:0] encode_sextet(input logic [5:0] idx);
        logic [6:0] code;
        logic [6:0] wide;
        wide = {1'b0, idx};
        if (idx < 6'd26) begin
            code = 7'd65 + wide;
        end else if (idx < 6'd52) begin
            code = 7'd71 + wide;
        end else if (idx < 6'd62) begin
            code = wide - 7'd4;
        end else if (idx == 6'd62) begin
            code = 7'd43;
        end else begin
            code = 7'd47;
        end
        return code;
    endfunction

endpackage

// ----- sv/base64_stream_encoder.sv -----
// base64 encoder: one message byte in, one to four characters out
// path: a byte's characters pass through the queue, the request register and the output register
// throughput: one character per cycle while m_tready is high, set by the output register;
// the queue lets new bytes be taken while earlier characters are still going out
// reset: synchronous, active low; clears leftover bits, queue and output valid
module base64_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
    output logic       m_tlast
);

    b64_pkg::entry_t push_entry;
    b64_pkg::entry_t head_entry;
    logic            push;
    logic            pop;
    logic            full;
    logic            not_empty;
    logic [6:0]      char_code;

    // byte intake and sextet split
    b64_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .q_full     (full),
        .q_push     (push),
        .q_entry    (push_entry)
    );

    // short queue between front and back
    b64_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head_entry (head_entry)
    );

    // character serialiser with output register
    b64_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (not_empty),
        .q_head      (head_entry),
        .q_pop       (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .char_code   (char_code),
        .last_char   (m_tlast)
    );

    assign m_tdata = {1'b0, char_code};

endmodule

// ----- sv/b64_front.sv -----
module b64_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             final_byte,
    input  logic             q_full,
    output logic             q_push,
    output b64_pkg::entry_t  q_entry
);

    logic [3:0] bits_reg;
    logic [3:0] bits_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [3:0] rem_bits;
    logic [2:0] rem_count;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // split the byte into sextets and build the character group
    always_comb begin
        q_entry.chars    = {4{b64_pkg::PAD_CODE}};
        q_entry.last_idx = 2'd0;
        q_entry.fin      = final_byte;
        rem_bits         = 4'd0;
        rem_count        = b64_pkg::CNT_ZERO;
        case (count_reg)
            b64_pkg::CNT_ZERO: begin
                q_entry.chars[0] = b64_pkg::encode_sextet(data_byte[7:2]);
                rem_bits         = {2'b00, data_byte[1:0]};
                rem_count        = b64_pkg::CNT_TWO;
                if (final_byte) begin
                    q_entry.chars[1] = b64_pkg::encode_sextet({data_byte[1:0], 4'b0000});
                    q_entry.last_idx = 2'd3;
                end
            end
            b64_pkg::CNT_TWO: begin
                q_entry.chars[0] = b64_pkg::encode_sextet({bits_reg[1:0], data_byte[7:4]});
                rem_bits         = data_byte[3:0];
                rem_count        = b64_pkg::CNT_FOUR;
                if (final_byte) begin
                    q_entry.chars[1] = b64_pkg::encode_sextet({data_byte[3:0], 2'b00});
                    q_entry.last_idx = 2'd2;
                end
            end
            default: begin
                q_entry.chars[0] = b64_pkg::encode_sextet({bits_reg, data_byte[7:6]});
                q_entry.chars[1] = b64_pkg::encode_sextet(data_byte[5:0]);
                q_entry.last_idx = 2'd1;
            end
        endcase
    end

    // leftover state, cleared after the final byte
    always_comb begin
        bits_next  = bits_reg;
        count_next = count_reg;
        if (q_push) begin
            if (final_byte) begin
                bits_next  = 4'd0;
                count_next = b64_pkg::CNT_ZERO;
            end else begin
                bits_next  = rem_bits;
                count_next = rem_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg  <= 4'd0;
            count_reg <= b64_pkg::CNT_ZERO;
        end else begin
            bits_reg  <= bits_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/b64_queue.sv -----
module b64_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  b64_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output b64_pkg::entry_t  head_entry
);

    localparam int PtrW = $clog2(b64_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(b64_pkg::QUEUE_DEPTH + 1);

    b64_pkg::entry_t mem_reg [b64_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] fill_reg;
    logic [CntW-1:0] fill_next;

    assign full       = (fill_reg == CntW'(b64_pkg::QUEUE_DEPTH));
    assign not_empty  = (fill_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(b64_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(b64_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- sv/b64_back.sv -----
module b64_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_not_empty,
    input  b64_pkg::entry_t  q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [6:0]       char_code,
    output logic             last_char
);

    b64_pkg::entry_t cur_reg;
    logic [1:0]      pos_reg;
    logic [1:0]      pos_next;
    logic            have_reg;
    logic            have_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [6:0]      char_reg;
    logic            last_reg;
    logic            slot_free;
    logic            emit;
    logic            at_end;

    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = have_reg && slot_free;
    assign at_end    = (pos_reg == cur_reg.last_idx);
    assign q_pop     = q_not_empty && (!have_reg || (emit && at_end));

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    // walk through the characters of the current request
    always_comb begin
        pos_next       = pos_reg;
        have_next      = have_reg;
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            pos_next       = pos_reg + 1'b1;
            if (at_end) begin
                have_next = 1'b0;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        if (q_pop) begin
            have_next = 1'b1;
            pos_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 2'd0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
        if (emit) begin
            char_reg <= cur_reg.chars[pos_reg];
            last_reg <= cur_reg.fin && at_end;
        end
    end

endmodule

// ----- tb/base64_stream_encoder_tb.sv -----
module base64_stream_encoder_tb;

    // one expected output character
    typedef struct {
        logic [6:0] code;
        logic       last_char;
    } b64_char_t;

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS_PER_PHASE = 34;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;   // [7:0] data_byte
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [6:0] char_code, [7] zero
    logic       m_tlast;

    // encoder state mirrored by the testbench
    logic [3:0] held_bits = 4'd0;
    int unsigned held_count = 0;

    b64_char_t expected_chars[$];
    string     alphabet_str = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;

    base64_stream_encoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // ascii code of one sextet
    function automatic logic [6:0] sextet_code(input int unsigned sextet);
        byte c;
        c = alphabet_str[sextet & 6'h3f];
        return c[6:0];
    endfunction

    // work out the characters one byte gives and queue them
    function automatic void encode_byte(input logic [7:0] data_byte, input logic final_byte);
        int unsigned acc;
        int unsigned nbits;
        int unsigned pads;
        b64_char_t   chars[$];
        b64_char_t   c;
        acc = ({held_bits, data_byte}) & ((1 << (held_count + 8)) - 1);
        nbits = held_count + 8;
        pads = 0;
        c.last_char = 1'b0;
        // whole sextets from the top end
        while (nbits >= 6) begin
            nbits = nbits - 6;
            c.code = sextet_code(acc >> nbits);
            chars = {chars, c};
        end
        acc = acc & ((1 << nbits) - 1);
        if (!final_byte) begin
            held_bits = acc[3:0];
            held_count = nbits;
        end else begin
            // leftover bits shifted up, then pads to a multiple of four
            if (nbits > 0) begin
                c.code = sextet_code(acc << (6 - nbits));
                chars = {chars, c};
                pads = (nbits == 2) ? 2 : 1;
            end
            for (int p = 0; p < pads; p++) begin
                c.code = b64_pkg::PAD_CODE;
                chars = {chars, c};
            end
            chars[chars.size() - 1].last_char = 1'b1;
            held_bits = 4'd0;
            held_count = 0;
        end
        foreach (chars[i]) expected_chars = {expected_chars, chars[i]};
    endfunction

    // offer one byte, with random idle cycles first, and wait for its request
    task automatic send_byte(input logic [7:0] data_byte, input logic final_byte);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data_byte;
        s_tlast <= final_byte;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        encode_byte(data_byte, final_byte);
    endtask

    // short messages covering every pad case and both alphabet ends
    task automatic test_known_vectors();
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h4d, 1'b0);
        send_byte(8'h61, 1'b1);
        send_byte(8'h4d, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6e, 1'b1);
        send_byte(8'hfb, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hbf, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h7f, 1'b1);
    endtask

    // random messages of one to eight bytes
    task automatic test_random_messages(input int n_items);
        int left;
        int msg_len;
        left = n_items;
        while (left > 0) begin
            msg_len = $urandom_range(8, 1);
            if (msg_len > left) msg_len = left;
            for (int i = 0; i < msg_len; i++) begin
                send_byte(8'($urandom_range(255, 0)), i == msg_len - 1);
            end
            left = left - msg_len;
        end
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // compare each accepted character with the oldest expectation
    always @(posedge aclk) begin
        b64_char_t exp_c;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character, expected none, got %0d last %0b",
                         $time, m_tdata[6:0], m_tlast);
                mismatch_count++;
            end else begin
                exp_c = expected_chars.pop_front();
                if (m_tdata[6:0] !== exp_c.code) begin
                    $display("%0t: char_code expected %0d, got %0d",
                             $time, exp_c.code, m_tdata[6:0]);
                    mismatch_count++;
                end
                if (m_tlast !== exp_c.last_char) begin
                    $display("%0t: last_char expected %0b, got %0b",
                             $time, exp_c.last_char, m_tlast);
                    mismatch_count++;
                end
                if (m_tdata[7] !== 1'b0) begin
                    $display("%0t: m_tdata[7] expected 0, got %0b", $time, m_tdata[7]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any request
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles lightly, receiver heavily
        src_idle_pct = 19;
        dst_idle_pct = 62;
        test_known_vectors();
        test_random_messages(RANDOM_ITEMS_PER_PHASE);

        // the other way round
        src_idle_pct = 62;
        dst_idle_pct = 19;
        test_random_messages(RANDOM_ITEMS_PER_PHASE);

        // full rate on both sides
        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random_messages(RANDOM_ITEMS_PER_PHASE);

        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
